/* design/gaq_pkg.sv */
// Shared types and constants for the gravity-alignment quaternion pipeline.
// No dependencies; imported by gravity_align_quaternion.
`default_nettype none

package gaq_pkg;

    // Widths after the sample has been scaled into [2^29, 2^30)
    localparam int M_W        = 31;  // scaled sample magnitude
    localparam int SQ_W       = 62;  // sum of squares
    localparam int RT_W       = 63;  // square-root working width
    localparam int N_W        = 31;  // square-root result
    localparam int F_W        = 32;  // n + |d|
    localparam int QM_W       = 62;  // raw quaternion magnitude
    localparam int QN_W       = 30;  // quaternion magnitude after range reduction
    localparam int REM_W      = 32;  // divider remainder
    localparam int SQRT_STEPS = 31;
    localparam int SCALE_TOP  = 29;  // leading one lands here after scaling
    localparam int POS_W      = 6;
    localparam int SH_W       = 5;

    localparam logic [2:0] AXIS_PZ    = 3'd0;
    localparam logic [2:0] AXIS_NZ    = 3'd1;
    localparam logic [2:0] AXIS_PY    = 3'd2;
    localparam logic [2:0] AXIS_NY    = 3'd3;
    localparam logic [2:0] AXIS_PX    = 3'd4;
    localparam logic [2:0] AXIS_NX    = 3'd5;
    localparam logic [2:0] AXIS_RESET = AXIS_NY;

    localparam logic [1:0] K_X = 2'd0;
    localparam logic [1:0] K_Y = 2'd1;
    localparam logic [1:0] K_Z = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OPP  = 2'd2;

    // Carried through the first square root
    typedef struct packed {
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic [SQ_W-1:0]     p;
        logic                zero;
    } t_pay_a;

    // Flags that pick the final result
    typedef struct packed {
        logic       zero;
        logic       pzero;
        logic       dneg;
        logic [2:0] qneg;
    } t_pay_b;

    // Carried through the second square root
    typedef struct packed {
        logic [3:0][QN_W-1:0] qn;
        t_pay_b               b;
    } t_pay_c;

endpackage

`default_nettype wire

/* design/gravity_align_quaternion.sv */
// Throughput: one sample per cycle; the whole pipeline holds while a result is not taken.
// The pipeline holds two 31-stage square-root pipelines and a FRACTION_BITS+1 stage divider.
// Reset (synchronous, active low) empties the pipeline and sets the reference axis to -Y.
// Gravity-alignment quaternion: scale, cross/dot terms, square roots, normalizing divide.
// Depends on gaq_pkg.
`default_nettype none

module gravity_align_quaternion #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]   i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]   i_accel_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [FRACTION_BITS+1:0] o_quat_x,
    output logic signed [FRACTION_BITS+1:0] o_quat_y,
    output logic signed [FRACTION_BITS+1:0] o_quat_z,
    output logic [FRACTION_BITS:0]          o_quat_w,
    output logic [1:0]                      o_status
);
    import gaq_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int FB        = FRACTION_BITS;
    localparam int Q_W       = FB + 1;
    localparam int DV_W      = QN_W + FB + 1;
    localparam int DIV_STEPS = FB + 1;
    localparam int LAT       = 5 + SQRT_STEPS + 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FB;

    // ---------------- configuration and control ----------------
    logic [2:0]     r_axis;
    logic [1:0]     k;
    logic           sgneg;
    logic           en;
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_RESET;
        end else if (i_cfg_we) begin
            r_axis <= (i_cfg_wdata > AXIS_NX) ? AXIS_NX : i_cfg_wdata;
        end
    end

    always_comb begin
        unique case (r_axis)
            AXIS_PZ, AXIS_NZ: k = K_Z;
            AXIS_PY, AXIS_NY: k = K_Y;
            default:          k = K_X;
        endcase
    end
    assign sgneg = r_axis[0];

    assign o_valid = r_vld[LAT-1];
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- S1: magnitudes ----------------
    logic [2:0][SB-1:0] n_s1_mag, r_s1_mag;
    logic [2:0]         n_s1_neg, r_s1_neg;
    logic signed [SB-1:0] acc [3];

    assign acc[0] = i_accel_x;
    assign acc[1] = i_accel_y;
    assign acc[2] = i_accel_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_neg[i] = acc[i][SB-1];
            n_s1_mag[i] = acc[i][SB-1] ? $unsigned(-acc[i]) : $unsigned(acc[i]);
        end
    end

    // ---------------- S2: scale amount ----------------
    logic [SB-1:0]      orv;
    logic [POS_W-1:0]   pos_s;
    logic [2:0][SB-1:0] r_s2_mag;
    logic [2:0]         r_s2_neg;
    logic [SH_W-1:0]    n_s2_sh, r_s2_sh;
    logic               n_s2_big, r_s2_big, r_s2_zero;

    always_comb begin
        orv      = r_s1_mag[0] | r_s1_mag[1] | r_s1_mag[2];
        pos_s    = '0;
        n_s2_big = 1'b0;
        for (int b = 0; b < SB; b++) begin
            if (orv[b]) pos_s = POS_W'(b);
        end
        for (int i = 0; i < 3; i++) begin
            if (33'(r_s1_mag[i]) > (33'(1) << 30)) n_s2_big = 1'b1;
        end
        n_s2_sh = (pos_s < POS_W'(SCALE_TOP)) ? SH_W'(POS_W'(SCALE_TOP) - pos_s) : '0;
    end

    // ---------------- S3: apply scale ----------------
    logic [2:0][M_W-1:0] n_s3_m, r_s3_m;
    logic [2:0]          r_s3_neg;
    logic                r_s3_zero;
    logic [63:0]         ext;

    always_comb begin
        ext = '0;
        for (int i = 0; i < 3; i++) begin
            ext       = r_s2_big ? (64'(r_s2_mag[i]) >> 1) : (64'(r_s2_mag[i]) << r_s2_sh);
            n_s3_m[i] = ext[M_W-1:0];
        end
    end

    // ---------------- S4: squares ----------------
    logic [2:0][SQ_W-1:0] r_s4_sq;
    logic [2:0][M_W-1:0]  r_s4_m;
    logic [2:0]           r_s4_neg;
    logic                 r_s4_zero;

    // ---------------- S5: sums ----------------
    logic [SQ_W-1:0] n_s5_p;
    logic [SQ_W-1:0] r_s5_x;
    t_pay_a          r_s5_pay;

    always_comb begin
        unique case (k)
            K_Z:     n_s5_p = r_s4_sq[0] + r_s4_sq[1];
            K_Y:     n_s5_p = r_s4_sq[0] + r_s4_sq[2];
            default: n_s5_p = r_s4_sq[1] + r_s4_sq[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mag  <= n_s1_mag;
            r_s1_neg  <= n_s1_neg;
            r_s2_mag  <= r_s1_mag;
            r_s2_neg  <= r_s1_neg;
            r_s2_sh   <= n_s2_sh;
            r_s2_big  <= n_s2_big;
            r_s2_zero <= (orv == '0);
            r_s3_m    <= n_s3_m;
            r_s3_neg  <= r_s2_neg;
            r_s3_zero <= r_s2_zero;
            for (int i = 0; i < 3; i++) begin
                r_s4_sq[i] <= SQ_W'(r_s3_m[i]) * SQ_W'(r_s3_m[i]);
            end
            r_s4_m        <= r_s3_m;
            r_s4_neg      <= r_s3_neg;
            r_s4_zero     <= r_s3_zero;
            r_s5_x        <= r_s4_sq[0] + r_s4_sq[1] + r_s4_sq[2];
            r_s5_pay.m    <= r_s4_m;
            r_s5_pay.neg  <= r_s4_neg;
            r_s5_pay.p    <= n_s5_p;
            r_s5_pay.zero <= r_s4_zero;
        end
    end

    // ---------------- first square root: |a| ----------------
    logic [RT_W-1:0] r_r1x [SQRT_STEPS];
    logic [RT_W-1:0] r_r1r [SQRT_STEPS];
    t_pay_a          r_r1p [SQRT_STEPS];
    logic [RT_W-1:0] n_r1x [SQRT_STEPS];
    logic [RT_W-1:0] n_r1r [SQRT_STEPS];

    always_comb begin
        logic [RT_W-1:0] ix, ir, t, bt;
        for (int g = 0; g < SQRT_STEPS; g++) begin
            ix = (g == 0) ? RT_W'(r_s5_x) : r_r1x[(g == 0) ? 0 : g - 1];
            ir = (g == 0) ? '0 : r_r1r[(g == 0) ? 0 : g - 1];
            bt = RT_W'(1) << (2 * (SQRT_STEPS - 1 - g));
            t  = ir + bt;
            if (ix >= t) begin
                n_r1x[g] = ix - t;
                n_r1r[g] = (ir >> 1) + bt;
            end else begin
                n_r1x[g] = ix;
                n_r1r[g] = ir >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int g = 0; g < SQRT_STEPS; g++) begin
                r_r1x[g] <= n_r1x[g];
                r_r1r[g] <= n_r1r[g];
                r_r1p[g] <= (g == 0) ? r_s5_pay : r_r1p[(g == 0) ? 0 : g - 1];
            end
        end
    end

    // ---------------- Q1: cross product and scalar term ----------------
    t_pay_a              pa;
    logic [N_W-1:0]      nroot;
    logic [2:0][M_W-1:0] n_q1_crm, r_q1_crm;
    logic [2:0]          crneg;
    logic [M_W-1:0]      dmag;
    logic                dneg;
    logic [F_W-1:0]      sum_nd, r_q1_f;
    logic [QM_W-1:0]     r_q1_q3;
    t_pay_b              n_q1_b, r_q1_b;

    assign pa    = r_r1p[SQRT_STEPS-1];
    assign nroot = r_r1r[SQRT_STEPS-1][N_W-1:0];

    always_comb begin
        unique case (k)
            K_Z: begin
                n_q1_crm = {{M_W{1'b0}}, pa.m[0], pa.m[1]};
                crneg    = {1'b0, pa.neg[0], !pa.neg[1]};
                dmag     = pa.m[2];
                dneg     = pa.neg[2];
            end
            K_Y: begin
                n_q1_crm = {pa.m[0], {M_W{1'b0}}, pa.m[2]};
                crneg    = {!pa.neg[0], 1'b0, pa.neg[2]};
                dmag     = pa.m[1];
                dneg     = pa.neg[1];
            end
            default: begin
                n_q1_crm = {pa.m[1], pa.m[2], {M_W{1'b0}}};
                crneg    = {pa.neg[1], !pa.neg[2], 1'b0};
                dmag     = pa.m[0];
                dneg     = pa.neg[0];
            end
        endcase
        // a zero dot term takes the non-negative path
        dneg         = (dneg ^ sgneg) && (dmag != '0);
        sum_nd       = F_W'(nroot) + F_W'(dmag);
        n_q1_b.zero  = pa.zero;
        n_q1_b.pzero = (pa.p == '0);
        n_q1_b.dneg  = dneg;
        n_q1_b.qneg  = crneg ^ {3{sgneg}};
    end

    // ---------------- Q2..Q6: scale down and sum of squares ----------------
    logic [3:0][QM_W-1:0]   r_q2_qm, r_q3_qm;
    t_pay_b                 r_q2_b, r_q3_b, r_q4_b;
    logic [QM_W-1:0]        orq;
    logic [POS_W-1:0]       pos_q, n_q3_sh, r_q3_sh;
    logic [3:0][QN_W-1:0]   n_q4_qn, r_q4_qn;
    logic [3:0][2*QN_W-1:0] r_q5_sq;
    t_pay_c                 r_q5_c, r_q6_c;
    logic [SQ_W-1:0]        r_q6_x;

    always_comb begin
        orq   = r_q2_qm[0] | r_q2_qm[1] | r_q2_qm[2] | r_q2_qm[3];
        pos_q = '0;
        for (int b = 0; b < QM_W; b++) begin
            if (orq[b]) pos_q = POS_W'(b);
        end
        n_q3_sh = (pos_q > POS_W'(SCALE_TOP)) ? pos_q - POS_W'(SCALE_TOP) : '0;
        for (int i = 0; i < 4; i++) begin
            n_q4_qn[i] = QN_W'(r_q3_qm[i] >> r_q3_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_crm <= n_q1_crm;
            r_q1_f   <= sum_nd;
            r_q1_q3  <= dneg ? pa.p : QM_W'(sum_nd);
            r_q1_b   <= n_q1_b;
            for (int i = 0; i < 3; i++) begin
                r_q2_qm[i] <= r_q1_b.dneg ? QM_W'(63'(r_q1_crm[i]) * 63'(r_q1_f))
                                          : QM_W'(r_q1_crm[i]);
            end
            r_q2_qm[3] <= r_q1_q3;
            r_q2_b     <= r_q1_b;
            r_q3_qm    <= r_q2_qm;
            r_q3_sh    <= n_q3_sh;
            r_q3_b     <= r_q2_b;
            r_q4_qn    <= n_q4_qn;
            r_q4_b     <= r_q3_b;
            for (int i = 0; i < 4; i++) begin
                r_q5_sq[i] <= (2*QN_W)'(r_q4_qn[i]) * (2*QN_W)'(r_q4_qn[i]);
            end
            r_q5_c.qn <= r_q4_qn;
            r_q5_c.b  <= r_q4_b;
            r_q6_x    <= SQ_W'(r_q5_sq[0]) + SQ_W'(r_q5_sq[1])
                       + SQ_W'(r_q5_sq[2]) + SQ_W'(r_q5_sq[3]);
            r_q6_c    <= r_q5_c;
        end
    end

    // ---------------- second square root: quaternion length ----------------
    logic [RT_W-1:0] r_r2x [SQRT_STEPS];
    logic [RT_W-1:0] r_r2r [SQRT_STEPS];
    t_pay_c          r_r2c [SQRT_STEPS];
    logic [RT_W-1:0] n_r2x [SQRT_STEPS];
    logic [RT_W-1:0] n_r2r [SQRT_STEPS];

    always_comb begin
        logic [RT_W-1:0] ix, ir, t, bt;
        for (int g = 0; g < SQRT_STEPS; g++) begin
            ix = (g == 0) ? RT_W'(r_q6_x) : r_r2x[(g == 0) ? 0 : g - 1];
            ir = (g == 0) ? '0 : r_r2r[(g == 0) ? 0 : g - 1];
            bt = RT_W'(1) << (2 * (SQRT_STEPS - 1 - g));
            t  = ir + bt;
            if (ix >= t) begin
                n_r2x[g] = ix - t;
                n_r2r[g] = (ir >> 1) + bt;
            end else begin
                n_r2x[g] = ix;
                n_r2r[g] = ir >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int g = 0; g < SQRT_STEPS; g++) begin
                r_r2x[g] <= n_r2x[g];
                r_r2r[g] <= n_r2r[g];
                r_r2c[g] <= (g == 0) ? r_q6_c : r_r2c[(g == 0) ? 0 : g - 1];
            end
        end
    end

    // ---------------- D0: rounded dividends ----------------
    t_pay_c                pc;
    logic [N_W-1:0]        len;
    logic [3:0][DV_W-1:0]  n_d0_dv, r_d0_dv;
    logic [3:0][REM_W-1:0] n_d0_rem, r_d0_rem;
    logic [N_W-1:0]        r_d0_len;
    t_pay_b                r_d0_b;

    assign pc  = r_r2c[SQRT_STEPS-1];
    assign len = r_r2r[SQRT_STEPS-1][N_W-1:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_d0_dv[i]  = (DV_W'(pc.qn[i]) << FB) + DV_W'(len >> 1);
            // quotient fits in FB+1 bits, so the upper part is already below len
            n_d0_rem[i] = REM_W'(n_d0_dv[i] >> (FB + 1));
        end
    end

    // ---------------- restoring dividers, one quotient bit per stage ----------------
    logic [3:0][REM_W-1:0] r_dr  [DIV_STEPS];
    logic [3:0][Q_W-1:0]   r_dq  [DIV_STEPS];
    logic [3:0][DV_W-1:0]  r_ddv [DIV_STEPS];
    logic [N_W-1:0]        r_dl  [DIV_STEPS];
    t_pay_b                r_db  [DIV_STEPS];
    logic [3:0][REM_W-1:0] n_dr  [DIV_STEPS];
    logic [3:0][Q_W-1:0]   n_dq  [DIV_STEPS];

    always_comb begin
        logic [REM_W-1:0] irem, rr;
        logic [Q_W-1:0]   iq;
        logic [DV_W-1:0]  idv;
        logic [N_W-1:0]   il;
        logic             ge;
        for (int g = 0; g < DIV_STEPS; g++) begin
            for (int i = 0; i < 4; i++) begin
                irem = (g == 0) ? r_d0_rem[i] : r_dr[(g == 0) ? 0 : g - 1][i];
                iq   = (g == 0) ? '0 : r_dq[(g == 0) ? 0 : g - 1][i];
                idv  = (g == 0) ? r_d0_dv[i] : r_ddv[(g == 0) ? 0 : g - 1][i];
                il   = (g == 0) ? r_d0_len : r_dl[(g == 0) ? 0 : g - 1];
                rr   = {irem[REM_W-2:0], idv[FB-g]};
                ge   = (rr >= REM_W'(il));
                n_dr[g][i] = ge ? rr - REM_W'(il) : rr;
                n_dq[g][i] = {iq[Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0_dv  <= n_d0_dv;
            r_d0_rem <= n_d0_rem;
            r_d0_len <= len;
            r_d0_b   <= pc.b;
            for (int g = 0; g < DIV_STEPS; g++) begin
                r_dr[g]  <= n_dr[g];
                r_dq[g]  <= n_dq[g];
                r_ddv[g] <= (g == 0) ? r_d0_dv  : r_ddv[(g == 0) ? 0 : g - 1];
                r_dl[g]  <= (g == 0) ? r_d0_len : r_dl[(g == 0) ? 0 : g - 1];
                r_db[g]  <= (g == 0) ? r_d0_b   : r_db[(g == 0) ? 0 : g - 1];
            end
        end
    end

    // ---------------- output word ----------------
    t_pay_b                     fb;
    logic [3:0][Q_W-1:0]        qv;
    logic signed [FB+1:0]       sv [3];
    logic signed [FB+1:0]       n_qx, n_qy, n_qz, r_qx, r_qy, r_qz;
    logic [FB:0]                n_qw, r_qw;
    logic [1:0]                 n_st, r_st;

    assign fb = r_db[DIV_STEPS-1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qv[i] = (r_dq[DIV_STEPS-1][i] > ONE_Q) ? ONE_Q : r_dq[DIV_STEPS-1][i];
        end
        for (int i = 0; i < 3; i++) begin
            sv[i] = fb.qneg[i] ? -$signed((FB+2)'(qv[i])) : $signed((FB+2)'(qv[i]));
        end
        priority if (fb.zero) begin
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
            n_qw = ONE_Q;
            n_st = ST_ZERO;
        end else if (fb.pzero && !fb.dneg) begin
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
            n_qw = ONE_Q;
            n_st = ST_OK;
        end else if (fb.pzero) begin
            // half turn: about Z for an X reference, else about X
            n_qx = (k == K_X) ? '0 : (FB+2)'(ONE_Q);
            n_qy = '0;
            n_qz = (k == K_X) ? (FB+2)'(ONE_Q) : '0;
            n_qw = '0;
            n_st = ST_OPP;
        end else begin
            n_qx = sv[0];
            n_qy = sv[1];
            n_qz = sv[2];
            n_qw = qv[3];
            n_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
            r_qw <= n_qw;
            r_st <= n_st;
        end
    end

    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;
    assign o_status = r_st;

`ifndef SYNTHESIS
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO |->
            o_quat_w == ONE_Q && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0)
        else $error("zero-sample word is not the identity");
    a_opp_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OPP |-> o_quat_w == '0)
        else $error("half-turn word has nonzero scalar part");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_ZERO || o_status == ST_OPP))
        else $error("undefined status code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid pipeline moved during a stall");
    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= AXIS_NX)
        else $error("reference axis register out of range");
`endif

endmodule

`default_nettype wire
